// ===== rtl/pcd_pkg.sv =====
`default_nettype none

package pcd_pkg;

   localparam int MAX_BYTES_DEFAULT = 2048;
   localparam logic [11:0] MAX_LEN_RESET = 12'd1500;

   // Header layout
   localparam int HEADER_LEN    = 8;
   localparam int PAYLOAD_START = 7;
   localparam int FLAG_POS      = 6;
   localparam int SEQ_LEN       = 4;
   localparam logic [10:0] LEN_MAX = 11'd2047;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CSUM_ERR = 2'd1;
   localparam logic [1:0] STATUS_RUNT     = 2'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_packet;
   } req_beat_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [1:0]  status;
      logic [7:0]  packet_flag;
      logic [31:0] sequence_number;
      logic [10:0] payload_length;
   } rsp_beat_type;

   // 16-bit ones-complement add with end-around carry
   function automatic logic [15:0] add_ones(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[15:0] + {15'd0, t[16]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pcd_chan_if.sv =====
`default_nettype none

interface pcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_packet;

   modport source (output valid, rx_byte, end_of_packet, input ready);
   modport sink   (input valid, rx_byte, end_of_packet, output ready);
endinterface

interface pcd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [1:0]  status;
   logic [7:0]  packet_flag;
   logic [31:0] sequence_number;
   logic [10:0] payload_length;

   modport source (output valid, result_kind, payload_byte, status, packet_flag,
                   sequence_number, payload_length, input ready);
   modport sink   (input valid, result_kind, payload_byte, status, packet_flag,
                   sequence_number, payload_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/pcd_input_stage.sv =====
`default_nettype none

module pcd_input_stage
   import pcd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         take,
   input  wire logic         drain,
   input  wire req_beat_type beat_in,
   output logic              valid,
   output req_beat_type      beat
);

   logic         valid_ff, valid_in;
   req_beat_type beat_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         beat_ff <= beat_in;
      end
   end

   assign valid = valid_ff;
   assign beat  = beat_ff;

endmodule

`default_nettype wire

// ===== rtl/pcd_parse_core.sv =====
`default_nettype none

module pcd_parse_core
   import pcd_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_beat_type beat,
   input  wire logic [11:0]  max_len,
   output logic              res_valid,
   output rsp_beat_type      res
);

   localparam int LIMIT_MAX = (MAX_BYTES < 4095) ? MAX_BYTES : 4095;
   localparam int POS_W     = $clog2(LIMIT_MAX + 1);

   logic [POS_W-1:0] pos_ff, pos_in, pos_upd;
   logic [15:0]      sum_ff, sum_in, sum_upd;
   logic [7:0]       pend_ff, pend_in, pend_upd;
   logic [31:0]      seq_ff, seq_in, seq_upd;
   logic [7:0]       flag_ff, flag_in, flag_upd;

   logic [POS_W-1:0] limit;
   logic [POS_W:0]   pos_inc;
   logic             in_range;
   logic             forward;
   logic [15:0]      sum_step;
   logic [15:0]      sum_odd;
   logic [15:0]      sum_final;
   logic [15:0]      len_wide;

   always_comb begin
      if (32'(max_len) > 32'(MAX_BYTES)) begin
         limit = POS_W'(MAX_BYTES);
      end else begin
         limit = POS_W'(max_len);
      end
   end

   always_comb begin
      in_range = pos_ff < limit;
      pos_inc  = {1'b0, pos_ff} + (POS_W+1)'(1);
      sum_step = add_ones(sum_ff, {pend_ff, beat.rx_byte});

      pos_upd  = pos_ff;
      sum_upd  = sum_ff;
      pend_upd = pend_ff;
      seq_upd  = seq_ff;
      flag_upd = flag_ff;
      if (in_range) begin
         if (!pos_ff[0]) begin
            pend_upd = beat.rx_byte;
         end else begin
            sum_upd = sum_step;
         end
         if (pos_ff < POS_W'(SEQ_LEN)) begin
            seq_upd = {seq_ff[23:0], beat.rx_byte};
         end
         if (pos_ff == POS_W'(FLAG_POS)) begin
            flag_upd = beat.rx_byte;
         end
         pos_upd = pos_inc[POS_W-1:0];
      end

      forward = in_range && !beat.end_of_packet
                && (pos_ff >= POS_W'(PAYLOAD_START)) && (pos_inc < {1'b0, limit});

      // odd length: lone byte padded with a zero low half
      sum_odd   = add_ones(sum_upd, {pend_upd, 8'h00});
      sum_final = pos_upd[0] ? sum_odd : sum_upd;
      len_wide  = 16'(pos_upd) - 16'(HEADER_LEN);

      res = '0;
      res_valid = 1'b0;
      if (forward) begin
         res_valid        = 1'b1;
         res.result_kind  = KIND_PAYLOAD;
         res.payload_byte = beat.rx_byte;
      end else if (beat.end_of_packet) begin
         res_valid       = 1'b1;
         res.result_kind = KIND_SUMMARY;
         if (pos_upd < POS_W'(HEADER_LEN)) begin
            res.status = STATUS_RUNT;
         end else begin
            res.status          = (sum_final == 16'hFFFF) ? STATUS_OK : STATUS_CSUM_ERR;
            res.packet_flag     = flag_upd;
            res.sequence_number = seq_upd;
            res.payload_length  = (len_wide > 16'(LEN_MAX)) ? LEN_MAX : len_wide[10:0];
         end
      end

      // a summary clears the per-packet state
      if (beat.end_of_packet) begin
         pos_in  = '0;
         sum_in  = '0;
         pend_in = '0;
         seq_in  = '0;
         flag_in = '0;
      end else begin
         pos_in  = pos_upd;
         sum_in  = sum_upd;
         pend_in = pend_upd;
         seq_in  = seq_upd;
         flag_in = flag_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sum_ff  <= '0;
         pend_ff <= '0;
         seq_ff  <= '0;
         flag_ff <= '0;
      end else if (step) begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         pend_ff <= pend_in;
         seq_ff  <= seq_in;
         flag_ff <= flag_in;
      end
   end

`ifndef SYNTHESIS
   a_eop_clears: assert property (@(posedge clock) disable iff (reset)
      step && beat.end_of_packet |=> (pos_ff == '0) && (sum_ff == '0))
      else $error("packet state not cleared after end of packet");

   a_trunc_ignored: assert property (@(posedge clock) disable iff (reset)
      step && !beat.end_of_packet && !in_range |=> $stable(sum_ff) && $stable(pos_ff))
      else $error("byte past limit changed packet state");

   a_fwd_payload: assert property (@(posedge clock) disable iff (reset)
      res_valid && (res.result_kind == KIND_PAYLOAD)
      |-> (pos_ff >= POS_W'(PAYLOAD_START)) && !beat.end_of_packet)
      else $error("header byte forwarded as payload");
`endif

endmodule

`default_nettype wire

// ===== rtl/pcd_output_stage.sv =====
`default_nettype none

module pcd_output_stage
   import pcd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire logic         taken,
   input  wire rsp_beat_type data_in,
   output logic              valid,
   output rsp_beat_type      data
);

   logic         valid_ff, valid_in;
   rsp_beat_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/packet_checksum_deframer.sv =====
// Receive-side datagram deframer. Bytes enter on req_chan one per beat, the
// last one flagged by end_of_packet. The block keeps a 16-bit ones-complement
// checksum over the kept bytes (big-endian pairs, a lone odd byte padded
// with zero), captures the sequence number from bytes 0..3 and the flag from
// byte 6, and forwards bytes from offset 7 up to but not including the last
// kept byte as payload beats (result_kind 0). The last byte produces one
// summary beat (result_kind 1) with status ok / checksum error / runt, flag,
// sequence number and payload length (bytes minus 8, saturating at 2047).
// Bytes past min(max_packet_len, MAX_BYTES) are dropped; an end marker on such
// a byte still closes the packet. max_packet_len is written through csr_we /
// csr_wdata, resets to 1500, and must only change while the block is idle.
// Throughput is one byte per clock while the result side keeps draining. An
// accepted byte sits in the input register until the result side is free;
// then the core's result for it, if any, is loaded into the result register
// and rsp_chan.valid rises. The per-byte work is one checksum add plus, on
// the last byte, the odd-byte pad add.
`default_nettype none

module packet_checksum_deframer
   import pcd_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   pcd_req_if.sink          req_chan,
   pcd_rsp_if.source        rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [11:0] csr_wdata
);

   logic [11:0]  max_len_ff;

   req_beat_type req_beat;
   req_beat_type s1_beat;
   logic         s1_valid;
   logic         out_free;
   logic         advance;
   logic         res_valid;
   rsp_beat_type res;
   logic         rsp_valid;
   rsp_beat_type rsp_beat;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_we) begin
         max_len_ff <= csr_wdata;
      end
   end

   // result register free this cycle, either empty or being drained
   assign out_free = !rsp_valid || rsp_chan.ready;
   // input beat moves through the core whenever the result side can take it
   assign advance  = s1_valid && out_free;

   assign req_chan.ready = !s1_valid || out_free;
   assign req_beat.rx_byte       = req_chan.rx_byte;
   assign req_beat.end_of_packet = req_chan.end_of_packet;

   pcd_input_stage u_in (
      .clock   (clock),
      .reset   (reset),
      .take    (req_chan.valid && req_chan.ready),
      .drain   (advance),
      .beat_in (req_beat),
      .valid   (s1_valid),
      .beat    (s1_beat)
   );

   pcd_parse_core #(
      .MAX_BYTES (MAX_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .beat      (s1_beat),
      .max_len   (max_len_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   pcd_output_stage u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (advance && res_valid),
      .taken   (rsp_chan.ready),
      .data_in (res),
      .valid   (rsp_valid),
      .data    (rsp_beat)
   );

   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.result_kind     = rsp_beat.result_kind;
   assign rsp_chan.payload_byte    = rsp_beat.payload_byte;
   assign rsp_chan.status          = rsp_beat.status;
   assign rsp_chan.packet_flag     = rsp_beat.packet_flag;
   assign rsp_chan.sequence_number = rsp_beat.sequence_number;
   assign rsp_chan.payload_length  = rsp_beat.payload_length;

`ifndef SYNTHESIS
   a_rsp_from_core: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(advance && res_valid))
      else $error("result beat appeared without a core result");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid && !out_free |=> s1_valid && $stable(s1_beat))
      else $error("input beat lost while result side stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/packet_checksum_deframer_tb.sv =====
module packet_checksum_deframer_tb
   import pcd_pkg::*;
();

   localparam int MAX_BYTES     = MAX_BYTES_DEFAULT;
   localparam int SETTLE_CYCLES = 4;     // idle clocks after the last awaited beat
   localparam int RSP_HOLD      = 150;   // long receiver hold-off, in cycles
   localparam int STALL_LIMIT   = 2000;  // cycles with no beat moving anywhere

   typedef enum {FILL_GOOD, FILL_CORRUPT, FILL_RANDOM, FILL_ZERO} frame_fill_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [11:0] csr_wdata;

   pcd_req_if req_if ();
   pcd_rsp_if rsp_if ();

   packet_checksum_deframer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: a software copy of the deframer's per-packet state
   // plus the length register.
   // ---------------------------------------------------------------------
   logic [11:0]  max_len_reg;
   logic [11:0]  cur_pos;       // bytes kept so far
   logic [15:0]  cur_sum;       // ones-complement sum of complete words
   logic [7:0]   cur_hi_byte;   // high half of the word being assembled
   logic [31:0]  cur_seq;
   logic [7:0]   cur_flag;

   rsp_beat_type awaited_beats[$];
   logic [7:0]   frame_q[$];    // frame being built for transmission

   int  mismatch_count = 0;
   int  bytes_counted  = 0;     // bytes accepted on the input channel
   int  stall_cycles   = 0;
   bit  req_gaps_on    = 1'b1;
   bit  rsp_gaps_on    = 1'b1;
   bit  rsp_hold_req   = 1'b0;

   function automatic logic [15:0] csum_add(input logic [15:0] acc, input logic [15:0] word);
      int unsigned t;
      t = 32'(acc) + 32'(word);
      t = (t & 32'hFFFF) + (t >> 16);
      return t[15:0];
   endfunction

   function automatic int eff_max_len();
      return (max_len_reg > MAX_BYTES) ? MAX_BYTES : int'(max_len_reg);
   endfunction

   function automatic void clear_frame_state();
      cur_pos     = '0;
      cur_sum     = '0;
      cur_hi_byte = '0;
      cur_seq     = '0;
      cur_flag    = '0;
   endfunction

   // One accepted byte: update state, queue the payload or summary beat it causes.
   function automatic void track_rx_byte(input logic [7:0] b, input logic eop);
      int unsigned  limit;
      int unsigned  pos;
      logic [15:0]  s;
      rsp_beat_type r;
      limit = eff_max_len();
      pos   = cur_pos;
      bytes_counted++;
      if (pos < limit) begin
         if (pos % 2 == 0)
            cur_hi_byte = b;
         else
            cur_sum = csum_add(cur_sum, {cur_hi_byte, b});
         if (pos < SEQ_LEN)
            cur_seq = {cur_seq[23:0], b};
         if (pos == FLAG_POS)
            cur_flag = b;
         cur_pos = 12'(pos + 1);
         // payload runs from offset 7 up to, not including, the last kept byte
         if (!eop && pos >= PAYLOAD_START && pos + 1 < limit) begin
            r = '0;
            r.result_kind  = KIND_PAYLOAD;
            r.payload_byte = b;
            awaited_beats.push_back(r);
         end
      end
      if (eop) begin
         r = '0;
         r.result_kind = KIND_SUMMARY;
         if (cur_pos < HEADER_LEN) begin
            r.status = STATUS_RUNT;
         end else begin
            s = cur_sum;
            if (cur_pos[0])
               s = csum_add(s, {cur_hi_byte, 8'h00});   // pad lone byte
            r.status          = (s == 16'hFFFF) ? STATUS_OK : STATUS_CSUM_ERR;
            r.packet_flag     = cur_flag;
            r.sequence_number = cur_seq;
            r.payload_length  = (cur_pos - HEADER_LEN > LEN_MAX) ?
                                LEN_MAX : 11'(cur_pos - HEADER_LEN);
         end
         awaited_beats.push_back(r);
         clear_frame_state();
      end
   endfunction

   // Input-side monitor: register writes and accepted beats feed the predictor.
   always @(posedge clock) begin
      if (reset) begin
         max_len_reg = MAX_LEN_RESET;
         clear_frame_state();
      end else begin
         if (csr_we)
            max_len_reg = csr_wdata;
         if (req_if.valid && req_if.ready)
            track_rx_byte(req_if.rx_byte, req_if.end_of_packet);
      end
   end

   function automatic void note_mismatch(input string what, input rsp_beat_type want,
                                         input rsp_beat_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch (%s) at %0t", what, $time);
         $display("  expected kind %0d byte %02h status %0d flag %02h seq %08h len %0d",
                  want.result_kind, want.payload_byte, want.status, want.packet_flag,
                  want.sequence_number, want.payload_length);
         $display("  actual   kind %0d byte %02h status %0d flag %02h seq %08h len %0d",
                  got.result_kind, got.payload_byte, got.status, got.packet_flag,
                  got.sequence_number, got.payload_length);
      end
   endfunction

   // Output-side checker: each accepted result beat against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_beat_type want;
      rsp_beat_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.result_kind     = rsp_if.result_kind;
         got.payload_byte    = rsp_if.payload_byte;
         got.status          = rsp_if.status;
         got.packet_flag     = rsp_if.packet_flag;
         got.sequence_number = rsp_if.sequence_number;
         got.payload_length  = rsp_if.payload_length;
         if (awaited_beats.size() == 0) begin
            note_mismatch("unexpected beat", '0, got);
         end else begin
            want = awaited_beats.pop_front();
            if (got.result_kind !== want.result_kind)
               note_mismatch("result_kind", want, got);
            if (got.payload_byte !== want.payload_byte)
               note_mismatch("payload_byte", want, got);
            if (got.status !== want.status)
               note_mismatch("status", want, got);
            if (got.packet_flag !== want.packet_flag)
               note_mismatch("packet_flag", want, got);
            if (got.sequence_number !== want.sequence_number)
               note_mismatch("sequence_number", want, got);
            if (got.payload_length !== want.payload_length)
               note_mismatch("payload_length", want, got);
         end
      end
   end

   // Receiver: random ready gaps per beat, or one long hold when asked.
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            gap = rsp_gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // Watchdog: nothing moving on either channel or the register port for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we)
      begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // One beat; valid stays high across back-to-back beats.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.rx_byte       <= b;
      req_if.end_of_packet <= is_last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_frame();
      foreach (frame_q[i])
         send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // Write bytes 4..5 so the kept prefix of the frame sums to 0xFFFF.
   function automatic void seal_frame();
      int          n;
      logic [15:0] s;
      n = (frame_q.size() < eff_max_len()) ? frame_q.size() : eff_max_len();
      if (n < 6)
         return;
      frame_q[4] = 8'h00;
      frame_q[5] = 8'h00;
      s = '0;
      for (int i = 0; i < n; i += 2)
         s = csum_add(s, {frame_q[i], (i + 1 < n) ? frame_q[i + 1] : 8'h00});
      {frame_q[4], frame_q[5]} = ~s;
   endfunction

   function automatic void build_frame(input int len, input frame_fill_type fill);
      int n;
      int idx;
      frame_q.delete();
      for (int i = 0; i < len; i++)
         frame_q.push_back((fill == FILL_ZERO) ? 8'h00 : 8'($urandom_range(0, 255)));
      if (fill == FILL_GOOD || fill == FILL_CORRUPT)
         seal_frame();
      n = (len < eff_max_len()) ? len : eff_max_len();
      if (fill == FILL_CORRUPT && n > 0) begin
         idx = $urandom_range(0, n - 1);
         frame_q[idx] = frame_q[idx] ^ 8'(1 << $urandom_range(0, 7));
      end
   endfunction

   task automatic send_random_frame();
      int             len;
      frame_fill_type fill;
      case ($urandom_range(0, 9))
         0: len = $urandom_range(1, 7);
         1: len = $urandom_range(41, 200);
         default: len = $urandom_range(8, 40);
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: fill = FILL_GOOD;
         12, 13, 14, 15: fill = FILL_CORRUPT;
         16, 17, 18: fill = FILL_RANDOM;
         default: fill = FILL_ZERO;
      endcase
      build_frame(len, fill);
      send_frame();
   endtask

   // Stop offering, let every awaited beat arrive, then let the pipe settle.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (awaited_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [11:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [11:0] pick_max_len();
      case ($urandom_range(0, 7))
         0: return MAX_LEN_RESET;
         1: return 12'(MAX_BYTES);
         2: return 12'hFFF;
         3: return 12'($urandom_range(0, 7));
         4, 5: return 12'($urandom_range(8, 64));
         default: return 12'($urandom_range(65, 2047));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Runt, all-zero frame, odd and even lengths with extreme header fields.
   task automatic test_header_extremes();
      build_frame(1, FILL_RANDOM);
      frame_q[0] = 8'hFF;
      send_frame();
      // zero frame folds to 0x0000, which is not 0xFFFF: checksum error
      build_frame(8, FILL_ZERO);
      send_frame();
      // odd length, lone last byte gets padded; one payload beat
      build_frame(9, FILL_RANDOM);
      for (int i = 0; i < SEQ_LEN; i++)
         frame_q[i] = 8'hFF;
      frame_q[FLAG_POS] = 8'h00;
      seal_frame();
      send_frame();
      build_frame(8, FILL_RANDOM);
      for (int i = 0; i < SEQ_LEN; i++)
         frame_q[i] = 8'h00;
      frame_q[FLAG_POS] = 8'hFF;
      seal_frame();
      send_frame();
   endtask

   // Truncation, end marker on a dropped byte, limits below a header, clamp.
   task automatic test_length_limits();
      write_max_len(12'd8);
      build_frame(12, FILL_GOOD);
      send_frame();
      write_max_len(12'd0);          // nothing kept: closes as a runt
      build_frame(3, FILL_RANDOM);
      send_frame();
      write_max_len(12'd5);
      build_frame(9, FILL_GOOD);
      send_frame();
      write_max_len(12'hFFF);        // above MAX_BYTES, clamped
      build_frame(40, FILL_GOOD);
      send_frame();
      write_max_len(12'(MAX_BYTES));
      build_frame(24, FILL_CORRUPT);
      send_frame();
      write_max_len(MAX_LEN_RESET);
   endtask

   // Receiver holds off while the sender keeps offering: input must stall.
   task automatic test_backpressure();
      req_gaps_on  = 1'b0;
      rsp_hold_req = 1'b1;
      repeat (2) begin
         build_frame(48, FILL_GOOD);
         send_frame();
      end
      req_gaps_on = 1'b1;
   endtask

   // Random frames in phases, each phase under a fresh length limit.
   task automatic test_random_traffic(input int n_bytes);
      int stop_at;
      int phase_end;
      stop_at = bytes_counted + n_bytes;
      while (bytes_counted < stop_at) begin
         write_max_len(pick_max_len());
         phase_end = bytes_counted + 120;
         while (bytes_counted < phase_end && bytes_counted < stop_at)
            send_random_frame();
      end
      write_max_len(MAX_LEN_RESET);
   endtask

   // Back-to-back beats with no gaps on either side.
   task automatic test_burst();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      repeat (6)
         send_random_frame();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // Sender goes quiet until everything has come out, then resumes.
   task automatic test_drain_pause();
      repeat (2)
         send_random_frame();
      drain_results();
      repeat (3)
         send_random_frame();
   endtask

   initial begin
      req_if.valid         <= 1'b0;
      req_if.rx_byte       <= 8'h00;
      req_if.end_of_packet <= 1'b0;
      csr_we               <= 1'b0;
      csr_wdata            <= 12'h000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_header_extremes();
      test_length_limits();
      test_backpressure();
      test_random_traffic(400);
      test_burst();
      test_drain_pause();

      drain_results();
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
